@@ sv/fpm_pkg.sv @@
// Shared types and constants for the fixed-partition word memory.
// Holds the request/response payloads, operation and status codes, controller
// states and the command/status bundles between controller and datapath.
package fpm_pkg;

  localparam int MEM_WORDS_DEF  = 1024;
  localparam int OS_WORDS_DEF   = 256;
  localparam int PART_WORDS_DEF = 128;
  localparam int NUM_PARTS_DEF  = 6;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed field widths of the payloads.
  localparam int DATA_W = 32;
  localparam int BASE_W = 10;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_LOAD  = 3'd2,
    KIND_ALLOC = 3'd3,
    KIND_FREE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_ADDR   = 3'd1,
    STAT_LOAD_LIMIT = 3'd2,
    STAT_TOO_LARGE  = 3'd3,
    STAT_NONE_FREE  = 3'd4,
    STAT_FREE_REJ   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [11:0]              address;
    logic [11:0]              end_address;
    logic [9:0]               word_index;
    logic [10:0]              word_count;
    logic signed [DATA_W-1:0] data;
    logic [11:0]              size_needed;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [2:0]               status;
    logic [BASE_W-1:0]        base_out;
  } response_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PROBE,
    S_CHECK,
    S_MARK,
    S_FREE
  } state_t;

  typedef enum logic [1:0] {
    RA_INPUT,
    RA_REQ,
    RA_PROBE
  } raddr_sel_t;

  typedef enum logic [1:0] {
    RES_EXEC,
    RES_NONE_FREE,
    RES_ALLOC,
    RES_FREE_OK
  } res_sel_t;

  typedef struct packed {
    logic       capture;
    logic       clear_wr;
    logic       exec_wr;
    logic       probe_init;
    logic       probe_next;
    logic       mark_init;
    logic       mark_wr;
    logic       free_init;
    logic       free_wr;
    logic       out_load;
    raddr_sel_t raddr_sel;
    res_sel_t   res_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       out_ready;
    logic       clear_last;
    logic       alloc_ok;
    logic       free_ok;
    logic       probe_end;
    logic       probe_free;
    logic       mark_last;
    logic       free_last;
  } stat_t;

endpackage

@@ sv/fpm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the word store and the occupied map.
module fpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fpm_ctrl.sv @@
// Controller state machine of the fixed-partition memory.
// Depends on fpm_pkg for states and the command/status bundles.
module fpm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_stall,
  input  fpm_pkg::stat_t stat,
  output fpm_pkg::cmd_t  cmd
);

  fpm_pkg::state_t state;
  fpm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpm_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.raddr_sel = fpm_pkg::RA_REQ;
    cmd.res_sel   = fpm_pkg::RES_EXEC;
    request_stall = 1'b1;
    case (state)
      fpm_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = fpm_pkg::S_IDLE;
        end
      end
      fpm_pkg::S_IDLE: begin
        // The read port looks at the incoming address so that the data is
        // ready in the execute cycle.
        request_stall = 1'b0;
        cmd.raddr_sel = fpm_pkg::RA_INPUT;
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = fpm_pkg::S_EXEC;
        end
      end
      fpm_pkg::S_EXEC: begin
        case (stat.kind)
          fpm_pkg::KIND_ALLOC: begin
            if (stat.alloc_ok) begin
              cmd.probe_init = 1'b1;
              state_next     = fpm_pkg::S_PROBE;
            end else if (stat.out_ready) begin
              cmd.out_load = 1'b1;
              state_next   = fpm_pkg::S_IDLE;
            end
          end
          fpm_pkg::KIND_FREE: begin
            if (stat.free_ok) begin
              cmd.free_init = 1'b1;
              state_next    = fpm_pkg::S_FREE;
            end else if (stat.out_ready) begin
              cmd.out_load = 1'b1;
              state_next   = fpm_pkg::S_IDLE;
            end
          end
          default: begin
            if (stat.out_ready) begin
              cmd.exec_wr  = 1'b1;
              cmd.out_load = 1'b1;
              state_next   = fpm_pkg::S_IDLE;
            end
          end
        endcase
      end
      fpm_pkg::S_PROBE: begin
        cmd.raddr_sel = fpm_pkg::RA_PROBE;
        if (stat.probe_end) begin
          if (stat.out_ready) begin
            cmd.out_load = 1'b1;
            cmd.res_sel  = fpm_pkg::RES_NONE_FREE;
            state_next   = fpm_pkg::S_IDLE;
          end
        end else begin
          state_next = fpm_pkg::S_CHECK;
        end
      end
      fpm_pkg::S_CHECK: begin
        cmd.raddr_sel = fpm_pkg::RA_PROBE;
        if (stat.probe_free) begin
          cmd.mark_init = 1'b1;
          state_next    = fpm_pkg::S_MARK;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = fpm_pkg::S_PROBE;
        end
      end
      fpm_pkg::S_MARK: begin
        // The last mark is held back until the response register has room.
        if (!stat.mark_last) begin
          cmd.mark_wr = 1'b1;
        end else if (stat.out_ready) begin
          cmd.mark_wr  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.res_sel  = fpm_pkg::RES_ALLOC;
          state_next   = fpm_pkg::S_IDLE;
        end
      end
      fpm_pkg::S_FREE: begin
        if (!stat.free_last) begin
          cmd.free_wr = 1'b1;
        end else if (stat.out_ready) begin
          cmd.free_wr  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.res_sel  = fpm_pkg::RES_FREE_OK;
          state_next   = fpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fpm_pkg::S_IDLE;
      end
    endcase
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == fpm_pkg::S_EXEC)
    else $error("captured request did not move to execute");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_ready)
    else $error("response loaded while the response register was blocked");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.exec_wr, cmd.mark_wr, cmd.free_wr}))
    else $error("more than one memory write command at once");

  a_clear_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(state == fpm_pkg::S_CLEAR) |-> $past(stat.clear_last))
    else $error("clearing pass ended before the last word");

endmodule

@@ sv/fpm_datapath.sv @@
// Datapath of the fixed-partition memory: request register, word store and
// occupied map RAMs, walk pointers, range checks and the response register.
// Depends on fpm_pkg and fpm_ram.
module fpm_datapath #(
  parameter int MEM_WORDS  = fpm_pkg::MEM_WORDS_DEF,
  parameter int OS_WORDS   = fpm_pkg::OS_WORDS_DEF,
  parameter int PART_WORDS = fpm_pkg::PART_WORDS_DEF,
  parameter int NUM_PARTS  = fpm_pkg::NUM_PARTS_DEF,
  parameter int WORD_BITS  = fpm_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fpm_pkg::request_t   request,
  input  fpm_pkg::cmd_t       cmd,
  output fpm_pkg::stat_t      stat,
  output logic                response_valid,
  input  logic                response_stall,
  output fpm_pkg::response_t  response
);

  localparam int ADDR_W = $clog2(MEM_WORDS);
  // Wide enough for every address sum and partition base that is compared.
  localparam int SPAN_W = $clog2(OS_WORDS + (NUM_PARTS + 1) * PART_WORDS + MEM_WORDS + 8192);
  localparam int PIDX_W = $clog2(NUM_PARTS + 1);
  localparam logic [SPAN_W-1:0] MEM_W  = SPAN_W'(MEM_WORDS);
  localparam logic [SPAN_W-1:0] OS_W   = SPAN_W'(OS_WORDS);
  localparam logic [SPAN_W-1:0] PART_W = SPAN_W'(PART_WORDS);

  fpm_pkg::request_t  req;
  fpm_pkg::response_t resp_next;
  logic [ADDR_W-1:0]  ptr;
  logic [PIDX_W-1:0]  probe_idx;
  logic [SPAN_W-1:0]  probe_start;

  logic [SPAN_W-1:0] addr_w, end_w, widx_w, wcnt_w, need_w, in_addr_w;
  logic [SPAN_W-1:0] load_idx_w, ptr_w, ptr_inc_w, raddr_w;
  logic addr_bad, load_over, load_outside, write_ok, load_ok;

  logic                 word_we, occ_we;
  logic [ADDR_W-1:0]    word_waddr, occ_waddr;
  logic [WORD_BITS-1:0] word_wdata, word_rdata, word_in;
  logic                 occ_wdata, occ_rdata;

  assign addr_w    = SPAN_W'(req.address);
  assign end_w     = SPAN_W'(req.end_address);
  assign widx_w    = SPAN_W'(req.word_index);
  assign wcnt_w    = SPAN_W'(req.word_count);
  assign need_w    = SPAN_W'(req.size_needed);
  assign in_addr_w = SPAN_W'(request.address);
  assign ptr_w     = SPAN_W'(ptr);
  assign ptr_inc_w = ptr_w + SPAN_W'(1);
  assign load_idx_w = addr_w + widx_w;
  assign word_in   = WORD_BITS'($unsigned(req.data));

  assign addr_bad     = addr_w >= MEM_W;
  assign load_over    = (addr_w + wcnt_w) > MEM_W;
  assign load_outside = widx_w >= wcnt_w;
  assign write_ok     = (req.kind == fpm_pkg::KIND_WRITE) && !addr_bad;
  assign load_ok      = (req.kind == fpm_pkg::KIND_LOAD) && !load_over && !load_outside;

  always_comb begin
    stat.kind       = req.kind;
    stat.out_ready  = !response_valid || !response_stall;
    stat.clear_last = ptr_w == (MEM_W - SPAN_W'(1));
    stat.alloc_ok   = need_w <= PART_W;
    stat.free_ok    = !(addr_w < OS_W || end_w >= MEM_W || addr_w > end_w);
    stat.probe_end  = (probe_idx == PIDX_W'(NUM_PARTS)) || (probe_start >= MEM_W);
    stat.probe_free = !occ_rdata;
    stat.mark_last  = (ptr_inc_w >= probe_start + PART_W) || (ptr_inc_w >= MEM_W);
    stat.free_last  = ptr_w == end_w;
  end

  // Read address: the incoming request while idle, the held request, or the
  // base of the partition being probed.
  always_comb begin
    case (cmd.raddr_sel)
      fpm_pkg::RA_INPUT: raddr_w = in_addr_w;
      fpm_pkg::RA_PROBE: raddr_w = probe_start;
      default:           raddr_w = addr_w;
    endcase
  end

  always_comb begin
    word_we    = 1'b0;
    word_waddr = ptr;
    word_wdata = '0;
    occ_we     = 1'b0;
    occ_waddr  = ptr;
    occ_wdata  = 1'b0;
    if (cmd.clear_wr) begin
      word_we   = 1'b1;
      occ_we    = 1'b1;
      occ_wdata = ptr_w < OS_W;
    end else if (cmd.free_wr) begin
      word_we = 1'b1;
      occ_we  = 1'b1;
    end else if (cmd.mark_wr) begin
      occ_we    = 1'b1;
      occ_wdata = 1'b1;
    end else if (cmd.exec_wr) begin
      if (write_ok) begin
        word_we    = 1'b1;
        word_waddr = addr_w[ADDR_W-1:0];
        word_wdata = word_in;
      end else if (load_ok) begin
        word_we    = 1'b1;
        word_waddr = load_idx_w[ADDR_W-1:0];
        word_wdata = word_in;
        occ_we     = 1'b1;
        occ_waddr  = load_idx_w[ADDR_W-1:0];
        occ_wdata  = 1'b1;
      end
    end
  end

  fpm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_WORDS)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .raddr (raddr_w[ADDR_W-1:0]),
    .rdata (word_rdata)
  );

  fpm_ram #(
    .WIDTH (1),
    .DEPTH (MEM_WORDS)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (raddr_w[ADDR_W-1:0]),
    .rdata (occ_rdata)
  );

  always_comb begin
    resp_next = '0;
    case (cmd.res_sel)
      fpm_pkg::RES_EXEC: begin
        case (req.kind)
          fpm_pkg::KIND_READ: begin
            if (addr_bad) begin
              resp_next.status = fpm_pkg::STAT_BAD_ADDR;
            end else begin
              resp_next.read_data = fpm_pkg::DATA_W'(word_rdata);
            end
          end
          fpm_pkg::KIND_WRITE: begin
            if (addr_bad) begin
              resp_next.status = fpm_pkg::STAT_BAD_ADDR;
            end
          end
          fpm_pkg::KIND_LOAD: begin
            if (load_over) begin
              resp_next.status = fpm_pkg::STAT_LOAD_LIMIT;
            end else if (load_outside) begin
              resp_next.status = fpm_pkg::STAT_BAD_ADDR;
            end else begin
              resp_next.base_out = req.address[fpm_pkg::BASE_W-1:0];
            end
          end
          fpm_pkg::KIND_ALLOC: resp_next.status = fpm_pkg::STAT_TOO_LARGE;
          fpm_pkg::KIND_FREE:  resp_next.status = fpm_pkg::STAT_FREE_REJ;
          default:             resp_next.status = fpm_pkg::STAT_OK;
        endcase
      end
      fpm_pkg::RES_NONE_FREE: resp_next.status = fpm_pkg::STAT_NONE_FREE;
      fpm_pkg::RES_ALLOC:     resp_next.base_out = probe_start[fpm_pkg::BASE_W-1:0];
      default:                resp_next.status = fpm_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr            <= '0;
      response_valid <= 1'b0;
    end else begin
      if (cmd.mark_init) begin
        ptr <= probe_start[ADDR_W-1:0];
      end else if (cmd.free_init) begin
        ptr <= addr_w[ADDR_W-1:0];
      end else if (cmd.clear_wr || cmd.mark_wr || cmd.free_wr) begin
        ptr <= ptr + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        response_valid <= 1'b1;
      end else if (!response_stall) begin
        response_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    if (cmd.probe_init) begin
      probe_idx   <= '0;
      probe_start <= OS_W;
    end else if (cmd.probe_next) begin
      probe_idx   <= probe_idx + PIDX_W'(1);
      probe_start <= probe_start + PART_W;
    end
    if (cmd.out_load) begin
      response <= resp_next;
    end
  end

endmodule

@@ sv/fixed_partition_memory.sv @@
// Fixed-partition word memory. Read, write and load go from acceptance through the
// execute state to the response; the next request waits on request_stall until then.
// Allocation probes the partitions in turn and marks the free one, one mark a cycle;
// a range free clears one word a cycle. The last mark or clear waits for response room.
// After reset a clearing pass zeroes the store and marks the system region;
// request_stall stays high until it ends. Top level; uses fpm_pkg.
module fixed_partition_memory #(
  parameter int MEM_WORDS  = fpm_pkg::MEM_WORDS_DEF,
  parameter int OS_WORDS   = fpm_pkg::OS_WORDS_DEF,
  parameter int PART_WORDS = fpm_pkg::PART_WORDS_DEF,
  parameter int NUM_PARTS  = fpm_pkg::NUM_PARTS_DEF,
  parameter int WORD_BITS  = fpm_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  fpm_pkg::request_t  request,
  output logic               response_valid,
  input  logic               response_stall,
  output fpm_pkg::response_t response
);

  fpm_pkg::cmd_t  cmd;
  fpm_pkg::stat_t stat;

  fpm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  fpm_datapath #(
    .MEM_WORDS  (MEM_WORDS),
    .OS_WORDS   (OS_WORDS),
    .PART_WORDS (PART_WORDS),
    .NUM_PARTS  (NUM_PARTS),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .cmd            (cmd),
    .stat           (stat),
    .response_valid (response_valid),
    .response_stall (response_stall),
    .response       (response)
  );

endmodule
